// ===== rtl/imrm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and defaults of the mailbox ring matrix.
// Used by the top, front and back ends and the test files; depends on nothing.
package imrm_pkg;

  localparam int unsigned CpuCountDef    = 4;
  localparam int unsigned RingDepthDef   = 16;
  localparam int unsigned InlineBytesDef = 8;

  localparam logic OP_PUBLISH = 1'b0;
  localparam logic OP_DRAIN   = 1'b1;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_TOOLONG = 3'd2;
  localparam logic [2:0] ST_OVERFLW = 3'd3;
  localparam logic [2:0] ST_STALL   = 3'd4;
  localparam logic [2:0] ST_SEQFLT  = 3'd5;

  localparam logic [1:0] REG_HARD_RT = 2'd0;
  localparam logic [1:0] REG_MAX_TYP = 2'd1;
  localparam logic [1:0] REG_PRIOS   = 2'd2;
  localparam logic [1:0] REG_PSB     = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  source_cpu;
    logic [2:0]  dest_cpu;
    logic [7:0]  event_type;
    logic [3:0]  event_priority;
    logic [7:0]  origin_id;
    logic [3:0]  payload_len;
    logic [63:0] payload;
    logic [5:0]  budget;
    logic [5:0]  sink_space;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_type;
    logic [3:0]  out_priority;
    logic [7:0]  out_origin_id;
    logic [2:0]  from_cpu;
    logic [3:0]  out_len;
    logic [63:0] out_payload;
    logic [31:0] sequence_res;
    logic [5:0]  drained_count;
    logic [31:0] ring_drops;
    logic        last;
  } result_t;

  typedef struct packed {
    logic       hard_rt;
    logic [8:0] max_types;
    logic [4:0] prios;
    logic [5:0] psb;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic        invalid;
    logic        too_long;
    logic [2:0]  src;
    logic [2:0]  tgt;
    logic [7:0]  etype;
    logic [3:0]  prio;
    logic [7:0]  origin;
    logic [3:0]  len;
    logic [63:0] data;
    logic [5:0]  budget;
    logic [5:0]  sink;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  len;
    logic [7:0]  origin;
    logic [3:0]  prio;
    logic [7:0]  etype;
    logic [31:0] seq;
    logic [63:0] data;
  } slot_t;

endpackage

// ===== rtl/ipc_mailbox_ring_matrix.sv =====
`timescale 1ns / 1ps
// Top level of the mailbox ring matrix: configuration registers, front, back.
// Depends on imrm_pkg, imrm_front and imrm_back.
//
// Transactions enter on the push/full port as item_i. A publish stores an
// event in ring (source, target) and yields one result. A drain walks the
// source rings of one target in ascending order and yields one result per
// consumed event or sequence fault, then a summary, unless a stall or hard
// real-time fault ends it; last marks the end. Results leave on the empty/pop
// port as result_o, oldest first. A drain starts in idle, reads each event
// or fault in scan, wait and evaluate states (the slot RAM read is
// registered), passes a skipped or used-up source in a scan step and ends in
// scan and summary steps. One publish per cycle at best; drains run one at a
// time. Two-entry command and result queues decouple input and output. When
// pop is held low the result queue fills, the back end holds, then the
// command queue fills and full rises. Reset empties both queues, clears ring
// pointers and counters and restores register defaults; slots keep contents.
// Write registers over the APB port only while nothing is in flight.
module ipc_mailbox_ring_matrix #(
  parameter int unsigned CPU_COUNT    = imrm_pkg::CpuCountDef,
  parameter int unsigned RING_DEPTH   = imrm_pkg::RingDepthDef,
  parameter int unsigned INLINE_BYTES = imrm_pkg::InlineBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  input  imrm_pkg::item_t   item_i,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output imrm_pkg::result_t result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  imrm_pkg::cfg_t cfg_q;
  imrm_pkg::cmd_t cmd;
  logic           cmd_pop, cmd_empty;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hard_rt   <= 1'b0;
      cfg_q.max_types <= 9'd256;
      cfg_q.prios     <= 5'd16;
      cfg_q.psb       <= 6'd4;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        imrm_pkg::REG_HARD_RT: cfg_q.hard_rt   <= pwdata[0];
        imrm_pkg::REG_MAX_TYP: cfg_q.max_types <= pwdata[8:0];
        imrm_pkg::REG_PRIOS:   cfg_q.prios     <= pwdata[4:0];
        imrm_pkg::REG_PSB:     cfg_q.psb       <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      imrm_pkg::REG_HARD_RT: prdata = {31'd0, cfg_q.hard_rt};
      imrm_pkg::REG_MAX_TYP: prdata = {23'd0, cfg_q.max_types};
      imrm_pkg::REG_PRIOS:   prdata = {27'd0, cfg_q.prios};
      imrm_pkg::REG_PSB:     prdata = {26'd0, cfg_q.psb};
      default:               prdata = '0;
    endcase
  end

  imrm_front #(.CPU_COUNT(CPU_COUNT), .INLINE_BYTES(INLINE_BYTES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push_i      (push),
    .item_i      (item_i),
    .full_o      (full),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd),
    .cmd_empty_o (cmd_empty)
  );

  imrm_back #(.CPU_COUNT(CPU_COUNT), .RING_DEPTH(RING_DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );
endmodule

// ===== rtl/imrm_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
// No dependencies.
module imrm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/imrm_fifo.sv =====
`timescale 1ns / 1ps
// Two-entry queue of registered entries.
// No dependencies.
module imrm_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);
  logic [Width-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= !wr_q;
      end
      if (do_pop) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

// ===== rtl/imrm_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts transactions, checks operands and queues commands.
// Depends on imrm_pkg and imrm_fifo.
module imrm_front #(
  parameter int unsigned CPU_COUNT    = imrm_pkg::CpuCountDef,
  parameter int unsigned INLINE_BYTES = imrm_pkg::InlineBytesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  imrm_pkg::cfg_t  cfg_i,
  input  logic            push_i,
  input  imrm_pkg::item_t item_i,
  output logic            full_o,
  input  logic            cmd_pop_i,
  output imrm_pkg::cmd_t  cmd_o,
  output logic            cmd_empty_o
);
  localparam logic [3:0] NCpu = 4'(CPU_COUNT);
  localparam logic [3:0] NByt = 4'(INLINE_BYTES);

  imrm_pkg::cmd_t cmd;
  logic           bad_pub, bad_drn;

  always_comb begin
    bad_pub = ({1'b0, item_i.source_cpu} >= NCpu) || ({1'b0, item_i.dest_cpu} >= NCpu) ||
              (item_i.source_cpu == item_i.dest_cpu) ||
              ({1'b0, item_i.event_type} >= cfg_i.max_types) ||
              ({1'b0, item_i.event_priority} >= cfg_i.prios);
    bad_drn = ({1'b0, item_i.dest_cpu} >= NCpu);
    cmd.op       = item_i.opcode;
    cmd.invalid  = (item_i.opcode == imrm_pkg::OP_DRAIN) ? bad_drn : bad_pub;
    cmd.too_long = (item_i.payload_len > NByt);
    cmd.src      = item_i.source_cpu;
    cmd.tgt      = item_i.dest_cpu;
    cmd.etype    = item_i.event_type;
    cmd.prio     = item_i.event_priority;
    cmd.origin   = item_i.origin_id;
    cmd.len      = item_i.payload_len;
    cmd.budget   = item_i.budget;
    cmd.sink     = item_i.sink_space;
    for (int i = 0; i < 8; i++) begin
      cmd.data[i*8 +: 8] = (4'(i) < item_i.payload_len) ?
                           item_i.payload[i*8 +: 8] : 8'd0;
    end
  end

  imrm_fifo #(.Width($bits(imrm_pkg::cmd_t))) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (cmd),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_o),
    .empty_o (cmd_empty_o)
  );
endmodule

// ===== rtl/imrm_back.sv =====
`timescale 1ns / 1ps
// Back end: executes publish and drain commands against the ring matrix.
// Depends on imrm_pkg, imrm_ram and imrm_fifo.
module imrm_back #(
  parameter int unsigned CPU_COUNT  = imrm_pkg::CpuCountDef,
  parameter int unsigned RING_DEPTH = imrm_pkg::RingDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  imrm_pkg::cfg_t    cfg_i,
  input  imrm_pkg::cmd_t    cmd_i,
  input  logic              cmd_empty_i,
  output logic              cmd_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output imrm_pkg::result_t result_o
);
  localparam int unsigned NRing = CPU_COUNT * CPU_COUNT;
  localparam int unsigned RingW = $clog2(NRing);
  localparam int unsigned PtrW  = $clog2(RING_DEPTH);
  localparam int unsigned Depth = NRing * RING_DEPTH;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned SrcW  = $clog2(CPU_COUNT + 1);
  localparam logic [SrcW-1:0] NSrc = SrcW'(CPU_COUNT);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(RING_DEPTH - 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WAIT, S_EVAL, S_SUM} state_e;

  state_e            state_q, state_d;
  logic [PtrW-1:0]   head_q [NRing];
  logic [PtrW-1:0]   tail_q [NRing];
  logic [31:0]       nseq_q [NRing];
  logic [31:0]       lseq_q [NRing];
  logic [31:0]       ovf_q  [NRing];
  logic [PtrW-1:0]   head_d [NRing];
  logic [PtrW-1:0]   tail_d [NRing];
  logic [31:0]       nseq_d [NRing];
  logic [31:0]       lseq_d [NRing];
  logic [31:0]       ovf_d  [NRing];
  logic [2:0]        tgt_q, tgt_d;
  logic [5:0]        budget_q, budget_d, sink_q, sink_d;
  logic [5:0]        per_q, per_d, drained_q, drained_d;
  logic [SrcW-1:0]   src_q, src_d;

  logic              we, re, res_push, res_full;
  logic [AddrW-1:0]  waddr, raddr;
  imrm_pkg::slot_t   wslot, rslot;
  imrm_pkg::result_t res;
  logic [RingW-1:0]  pr, dr;
  logic [PtrW-1:0]   nxt;
  logic [31:0]       seq, diff;

  always_comb begin
    pr = RingW'(cmd_i.src) * RingW'(CPU_COUNT) + RingW'(cmd_i.tgt);
    dr = RingW'(src_q) * RingW'(CPU_COUNT) + RingW'(tgt_q);
  end

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    nseq_d    = nseq_q;
    lseq_d    = lseq_q;
    ovf_d     = ovf_q;
    tgt_d     = tgt_q;
    budget_d  = budget_q;
    sink_d    = sink_q;
    per_d     = per_q;
    drained_d = drained_q;
    src_d     = src_q;
    cmd_pop_o = 1'b0;
    res_push  = 1'b0;
    res       = '0;
    res.last  = 1'b1;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = AddrW'(pr) * AddrW'(RING_DEPTH) + AddrW'(head_q[pr]);
    raddr     = AddrW'(dr) * AddrW'(RING_DEPTH) + AddrW'(tail_q[dr]);
    nxt       = (head_q[pr] == PtrMax) ? '0 : head_q[pr] + PtrW'(1);
    seq       = nseq_q[pr] + 32'd1;
    if (seq == 32'd0) begin
      seq = 32'd1;
    end
    wslot.len    = cmd_i.len;
    wslot.origin = cmd_i.origin;
    wslot.prio   = cmd_i.prio;
    wslot.etype  = cmd_i.etype;
    wslot.seq    = seq;
    wslot.data   = cmd_i.data;
    diff = rslot.seq - lseq_q[dr];

    unique case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i && !res_full) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.invalid) begin
            res_push   = 1'b1;
            res.status = imrm_pkg::ST_INVALID;
          end else if (cmd_i.op == imrm_pkg::OP_DRAIN) begin
            tgt_d     = cmd_i.tgt;
            budget_d  = cmd_i.budget;
            sink_d    = cmd_i.sink;
            per_d     = '0;
            drained_d = '0;
            src_d     = '0;
            state_d   = S_SCAN;
          end else if (cmd_i.too_long) begin
            res_push       = 1'b1;
            res.status     = imrm_pkg::ST_TOOLONG;
            res.ring_drops = ovf_q[pr];
          end else if (nxt == tail_q[pr]) begin
            res_push       = 1'b1;
            ovf_d[pr]      = ovf_q[pr] + 32'd1;
            res.status     = imrm_pkg::ST_OVERFLW;
            res.ring_drops = ovf_q[pr] + 32'd1;
          end else begin
            res_push         = 1'b1;
            we               = 1'b1;
            nseq_d[pr]       = seq;
            head_d[pr]       = nxt;
            res.status       = imrm_pkg::ST_OK;
            res.sequence_res = seq;
            res.ring_drops   = ovf_q[pr];
          end
        end
      end
      S_SCAN: begin
        priority if (src_q == NSrc || drained_q >= budget_q) begin
          state_d = S_SUM;
        end else if (src_q == SrcW'(tgt_q) || per_q >= cfg_i.psb ||
                     tail_q[dr] == head_q[dr]) begin
          src_d = src_q + SrcW'(1);
          per_d = '0;
        end else begin
          re      = 1'b1;
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (!res_full) begin
          res_push     = 1'b1;
          res.from_cpu = 3'(src_q);
          if (rslot.seq == 32'd0 || diff == 32'd0 || diff[31]) begin
            tail_d[dr] = (tail_q[dr] == PtrMax) ? '0 : tail_q[dr] + PtrW'(1);
            per_d      = per_q + 6'd1;
            drained_d  = drained_q + 6'd1;
            res.status        = imrm_pkg::ST_SEQFLT;
            res.sequence_res  = rslot.seq;
            res.drained_count = drained_q + 6'd1;
            res.last          = cfg_i.hard_rt;
            state_d           = cfg_i.hard_rt ? S_IDLE : S_SCAN;
          end else if (sink_q == 6'd0) begin
            res.status        = imrm_pkg::ST_STALL;
            res.drained_count = drained_q;
            state_d           = S_IDLE;
          end else begin
            sink_d     = sink_q - 6'd1;
            lseq_d[dr] = rslot.seq;
            tail_d[dr] = (tail_q[dr] == PtrMax) ? '0 : tail_q[dr] + PtrW'(1);
            per_d      = per_q + 6'd1;
            drained_d  = drained_q + 6'd1;
            res.status        = imrm_pkg::ST_OK;
            res.out_type      = rslot.etype;
            res.out_priority  = rslot.prio;
            res.out_origin_id = rslot.origin;
            res.out_len       = rslot.len;
            res.out_payload   = rslot.data;
            res.sequence_res  = rslot.seq;
            res.drained_count = drained_q + 6'd1;
            res.last          = 1'b0;
            state_d           = S_SCAN;
          end
        end
      end
      S_SUM: begin
        if (!res_full) begin
          res_push          = 1'b1;
          res.status        = imrm_pkg::ST_OK;
          res.drained_count = drained_q;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      tgt_q     <= '0;
      budget_q  <= '0;
      sink_q    <= '0;
      per_q     <= '0;
      drained_q <= '0;
      src_q     <= '0;
      for (int i = 0; i < NRing; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        nseq_q[i] <= '0;
        lseq_q[i] <= '0;
        ovf_q[i]  <= '0;
      end
    end else begin
      state_q   <= state_d;
      tgt_q     <= tgt_d;
      budget_q  <= budget_d;
      sink_q    <= sink_d;
      per_q     <= per_d;
      drained_q <= drained_d;
      src_q     <= src_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      nseq_q    <= nseq_d;
      lseq_q    <= lseq_d;
      ovf_q     <= ovf_d;
    end
  end

  imrm_ram #(.Width($bits(imrm_pkg::slot_t)), .Depth(Depth)) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wslot),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rslot)
  );

  imrm_fifo #(.Width($bits(imrm_pkg::result_t))) u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .rdata_o (result_o),
    .empty_o (empty_o)
  );
endmodule

// ===== test/imrm_checker.sv =====
`timescale 1ns / 1ps
// Checker for the mailbox ring matrix: watches the input and result queues,
// predicts results from its own ring model and compares. Depends on imrm_pkg.
module imrm_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  input  logic              full,
  input  imrm_pkg::item_t   item_i,
  input  logic              empty,
  input  logic              pop,
  input  imrm_pkg::result_t result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                mismatch_cnt,
  output int                pending_cnt
);
  localparam int NCpu  = int'(imrm_pkg::CpuCountDef);
  localparam int Depth = int'(imrm_pkg::RingDepthDef);
  localparam int NByt  = int'(imrm_pkg::InlineBytesDef);
  localparam int NRing = NCpu * NCpu;

  int                head_q [NRing];
  int                tail_q [NRing];
  logic [31:0]       next_seq_q [NRing];
  logic [31:0]       last_seq_q [NRing];
  logic [31:0]       drops_q [NRing];
  imrm_pkg::slot_t   slots_q [NRing * Depth];
  logic              m_hard;
  logic [8:0]        m_types;
  logic [4:0]        m_prios;
  logic [5:0]        m_psb;
  imrm_pkg::result_t expected_q[$];

  function automatic logic [63:0] byte_mask(logic [3:0] len);
    if (len >= 4'd8) return '1;
    return (64'd1 << {len, 3'b000}) - 64'd1;
  endfunction

  function automatic imrm_pkg::result_t mk(logic [2:0] st, logic [2:0] from,
                                           logic [31:0] seq, logic [5:0] drained,
                                           logic [31:0] drops, logic lst);
    imrm_pkg::result_t r;
    r = '0;
    r.status = st;
    r.from_cpu = from;
    r.sequence_res = seq;
    r.drained_count = drained;
    r.ring_drops = drops;
    r.last = lst;
    return r;
  endfunction

  task automatic predict_publish(imrm_pkg::item_t it);
    int r, nxt;
    logic [31:0] seq;
    imrm_pkg::slot_t s;
    if (int'(it.source_cpu) >= NCpu || int'(it.dest_cpu) >= NCpu ||
        it.source_cpu == it.dest_cpu ||
        {1'b0, it.event_type} >= m_types || {1'b0, it.event_priority} >= m_prios) begin
      expected_q.push_back(mk(imrm_pkg::ST_INVALID, 3'd0, 32'd0, 6'd0, 32'd0, 1'b1));
      return;
    end
    r = int'(it.source_cpu) * NCpu + int'(it.dest_cpu);
    if (int'(it.payload_len) > NByt) begin
      expected_q.push_back(mk(imrm_pkg::ST_TOOLONG, 3'd0, 32'd0, 6'd0, drops_q[r], 1'b1));
      return;
    end
    nxt = (head_q[r] + 1) % Depth;
    if (nxt == tail_q[r]) begin
      drops_q[r] = drops_q[r] + 32'd1;
      expected_q.push_back(mk(imrm_pkg::ST_OVERFLW, 3'd0, 32'd0, 6'd0, drops_q[r], 1'b1));
      return;
    end
    seq = next_seq_q[r] + 32'd1;
    if (seq == 32'd0) seq = 32'd1;
    next_seq_q[r] = seq;
    s.len = it.payload_len;
    s.origin = it.origin_id;
    s.prio = it.event_priority;
    s.etype = it.event_type;
    s.seq = seq;
    s.data = it.payload & byte_mask(it.payload_len);
    slots_q[r * Depth + head_q[r]] = s;
    head_q[r] = nxt;
    expected_q.push_back(mk(imrm_pkg::ST_OK, 3'd0, seq, 6'd0, drops_q[r], 1'b1));
  endtask

  task automatic predict_drain(imrm_pkg::item_t it);
    int tgt, r, e, per;
    logic [5:0] drained, sink;
    logic [31:0] diff;
    imrm_pkg::slot_t s;
    imrm_pkg::result_t res;
    tgt = int'(it.dest_cpu);
    if (tgt >= NCpu) begin
      expected_q.push_back(mk(imrm_pkg::ST_INVALID, 3'd0, 32'd0, 6'd0, 32'd0, 1'b1));
      return;
    end
    drained = 6'd0;
    sink = it.sink_space;
    for (int src = 0; src < NCpu && drained < it.budget; src++) begin
      if (src != tgt) begin
        per = 0;
        r = src * NCpu + tgt;
        e = tgt * NCpu + src;
        while (per < int'(m_psb) && drained < it.budget && tail_q[r] != head_q[r]) begin
          s = slots_q[r * Depth + tail_q[r]];
          diff = s.seq - last_seq_q[e];
          if (s.seq == 32'd0 || diff == 32'd0 || diff[31]) begin
            tail_q[r] = (tail_q[r] + 1) % Depth;
            per++;
            drained = drained + 6'd1;
            expected_q.push_back(mk(imrm_pkg::ST_SEQFLT, 3'(src), s.seq, drained, 32'd0,
                                    m_hard));
            if (m_hard) return;
          end else if (sink == 6'd0) begin
            expected_q.push_back(mk(imrm_pkg::ST_STALL, 3'(src), 32'd0, drained, 32'd0,
                                    1'b1));
            return;
          end else begin
            sink = sink - 6'd1;
            last_seq_q[e] = s.seq;
            tail_q[r] = (tail_q[r] + 1) % Depth;
            per++;
            drained = drained + 6'd1;
            res = mk(imrm_pkg::ST_OK, 3'(src), s.seq, drained, 32'd0, 1'b0);
            res.out_type = s.etype;
            res.out_priority = s.prio;
            res.out_origin_id = s.origin;
            res.out_len = s.len;
            res.out_payload = s.data & byte_mask(s.len);
            expected_q.push_back(res);
          end
        end
      end
    end
    expected_q.push_back(mk(imrm_pkg::ST_OK, 3'd0, 32'd0, drained, 32'd0, 1'b1));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    imrm_pkg::result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NRing; i++) begin
        head_q[i] = 0;
        tail_q[i] = 0;
        next_seq_q[i] = '0;
        last_seq_q[i] = '0;
        drops_q[i] = '0;
      end
      m_hard = 1'b0;
      m_types = 9'd256;
      m_prios = 5'd16;
      m_psb = 6'd4;
      mismatch_cnt = 0;
      pending_cnt = 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          imrm_pkg::REG_HARD_RT: m_hard = pwdata[0];
          imrm_pkg::REG_MAX_TYP: m_types = pwdata[8:0];
          imrm_pkg::REG_PRIOS:   m_prios = pwdata[4:0];
          imrm_pkg::REG_PSB:     m_psb = pwdata[5:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected result %h", result_o);
        end else begin
          want = expected_q.pop_front();
          if (result_o !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("result mismatch: expected %h actual %h", want, result_o);
          end
        end
      end
      if (push && !full) begin
        if (item_i.opcode == imrm_pkg::OP_PUBLISH) predict_publish(item_i);
        else predict_drain(item_i);
      end
      pending_cnt = expected_q.size();
    end
  end
endmodule

// ===== test/tb_ipc_mailbox_ring_matrix.sv =====
`timescale 1ns / 1ps
// Testbench top for the mailbox ring matrix: drives publishes, drains and
// register writes with random idling; uses imrm_pkg, the DUT and imrm_checker.
module tb_ipc_mailbox_ring_matrix;
  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              push = 1'b0;
  logic              pop = 1'b0;
  imrm_pkg::item_t   item_i = '0;
  logic              full, empty, pready;
  imrm_pkg::result_t result_o;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  int                mismatch_cnt, pending_cnt;
  int                send_idle = 0, recv_idle = 0;
  int                quiet_cycles = 0;

  always #10 clk_i = ~clk_i;

  ipc_mailbox_ring_matrix DUT (
    .clk_i, .rst_ni, .push, .item_i, .full, .empty, .pop, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  imrm_checker u_checker (
    .clk_i, .rst_ni, .push, .full, .item_i, .empty, .pop, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .mismatch_cnt, .pending_cnt
  );

  always @(posedge clk_i) begin
    if (rst_ni) pop <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send(imrm_pkg::item_t it);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic settle;
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic imrm_pkg::item_t rand_item(bit sane);
    imrm_pkg::item_t it;
    logic [127:0]    rnd;
    rnd = {$urandom, $urandom, $urandom, $urandom};
    it = rnd[$bits(imrm_pkg::item_t)-1:0];
    if (sane) begin
      it.opcode = ($urandom_range(99) < 35) ? imrm_pkg::OP_DRAIN : imrm_pkg::OP_PUBLISH;
      it.source_cpu = 3'($urandom_range(3));
      it.dest_cpu = 3'($urandom_range(3));
      if (it.source_cpu == it.dest_cpu && it.opcode == imrm_pkg::OP_PUBLISH)
        it.dest_cpu = (it.source_cpu + 3'd1) & 3'd3;
      it.payload_len = 4'($urandom_range(8));
      it.event_priority = 4'($urandom_range(7));
      it.event_type = 8'($urandom_range(120));
      it.budget = 6'($urandom_range(20));
      it.sink_space = ($urandom_range(9) == 0) ? 6'd0 : 6'($urandom_range(20));
    end
    return it;
  endfunction

  function automatic imrm_pkg::item_t pub(int s, int t, int len, logic [63:0] pl);
    imrm_pkg::item_t it;
    it = '0;
    it.opcode = imrm_pkg::OP_PUBLISH;
    it.source_cpu = 3'(s);
    it.dest_cpu = 3'(t);
    it.event_type = 8'hA5;
    it.event_priority = 4'h3;
    it.origin_id = 8'h5A;
    it.payload_len = 4'(len);
    it.payload = pl;
    return it;
  endfunction

  function automatic imrm_pkg::item_t drn(int t, int b, int sk);
    imrm_pkg::item_t it;
    it = '0;
    it.opcode = imrm_pkg::OP_DRAIN;
    it.dest_cpu = 3'(t);
    it.budget = 6'(b);
    it.sink_space = 6'(sk);
    return it;
  endfunction

  initial begin
    imrm_pkg::item_t it;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle = 30;
    recv_idle = 69;
    reg_write(imrm_pkg::REG_PSB, 32'd63);
    send(pub(0, 1, 8, '1));
    send(pub(1, 0, 0, '1));
    send(pub(2, 3, 9, '1));
    send(pub(2, 2, 1, 64'd0));
    send(pub(7, 1, 1, 64'd0));
    it = pub(0, 1, 15, '1);
    it.event_type = 8'hFF;
    it.event_priority = 4'hF;
    it.origin_id = 8'hFF;
    send(it);
    for (int i = 0; i < 16; i++) send(pub(3, 1, i % 9, {$urandom, $urandom}));
    send(drn(1, 63, 0));
    send(drn(1, 5, 63));
    send(drn(1, 63, 63));
    send(drn(6, 63, 63));
    settle();
    reg_write(imrm_pkg::REG_HARD_RT, 32'd1);
    reg_write(imrm_pkg::REG_MAX_TYP, 32'd1);
    reg_write(imrm_pkg::REG_PRIOS, 32'd1);
    reg_write(imrm_pkg::REG_PSB, 32'd1);
    send(pub(0, 2, 3, 64'h123456));
    it = pub(0, 2, 3, 64'h1);
    it.event_type = 8'd0;
    it.event_priority = 4'd0;
    send(it);
    send(drn(2, 63, 63));
    settle();
    reg_write(imrm_pkg::REG_MAX_TYP, 32'd256);
    reg_write(imrm_pkg::REG_PRIOS, 32'd16);
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 1) begin
        send_idle = 69;
        recv_idle = 30;
      end else if (ph == 3) begin
        send_idle = 0;
        recv_idle = 0;
      end
      reg_write(imrm_pkg::REG_HARD_RT, {31'd0, ph[0]});
      reg_write(imrm_pkg::REG_PSB, (ph == 2) ? 32'd63 : $urandom_range(1, 8));
      reg_write(imrm_pkg::REG_MAX_TYP, (ph == 2) ? 32'd100 : 32'd256);
      reg_write(imrm_pkg::REG_PRIOS, (ph == 2) ? 32'd5 : 32'd16);
      for (int i = 0; i < 88; i++) send(rand_item($urandom_range(9) != 0));
      settle();
    end
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/imrm_pkg.sv
rtl/imrm_ram.sv
rtl/imrm_fifo.sv
rtl/imrm_front.sv
rtl/imrm_back.sv
rtl/ipc_mailbox_ring_matrix.sv
test/imrm_checker.sv
test/tb_ipc_mailbox_ring_matrix.sv
